@@ hw/rtl/rrhd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrhd_pkg
// Shared constants, types and helpers of the RAW hazard detector.
// ----------------------------------------------------------------------------
package rrhd_pkg;

  localparam int NUM_REGS    = 32;
  localparam int SEQ_WIDTH   = 16;
  localparam int REG_W       = 5;
  localparam int FUNC_W      = 2;
  localparam int NUM_W       = 16;
  localparam int IDX_W       = $clog2(NUM_REGS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_RTYPE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ITYPE = 2'd1;

  localparam logic [SEQ_WIDTH-1:0] SEQ_MAX = {SEQ_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RTYPE,
    OP_ITYPE
  } op_t;

  // Kind of the last access to a register.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_WRITE
  } kind_t;

  // Classified instruction as it travels from front to back.
  typedef struct packed {
    op_t                  op;
    logic [REG_W-1:0]     src_s;
    logic                 s_ok;
    logic [REG_W-1:0]     src_t;
    logic                 t_ok;
    logic [REG_W-1:0]     dest_d;
    logic                 d_ok;
    logic [SEQ_WIDTH-1:0] seq;
  } q_entry_t;

  // One read and one write of the register table per cycle.
  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [SEQ_WIDTH-1:0] seq;
  } tab_req_t;

  typedef struct packed {
    logic                 hazard;
    logic [SEQ_WIDTH-1:0] writer;
  } tab_rsp_t;

  function automatic logic reg_ok(input logic [REG_W-1:0] r);
    logic [REG_W:0] lim;
    lim = (REG_W+1)'(NUM_REGS);
    return {1'b0, r} < lim;
  endfunction

  function automatic logic [IDX_W-1:0] reg_idx(input logic [REG_W-1:0] r);
    logic [REG_W+IDX_W-1:0] ext;
    ext = {{IDX_W{1'b0}}, r};
    return ext[IDX_W-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] to_num(input logic [SEQ_WIDTH-1:0] s);
    logic [SEQ_WIDTH+NUM_W-1:0] ext;
    ext = {{NUM_W{1'b0}}, s};
    return ext[NUM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/register_raw_hazard_detector_core.sv @@
// ----------------------------------------------------------------------------
// register_raw_hazard_detector_core
// Read-after-write hazard detector over a stream of decoded instructions.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  input     start && !busy       in_func, in_src_s, in_src_t, in_dest_d
//  result    out_valid (strobe)   out_hazard_register, out_writer_number,
//                                 out_reader_number, out_last_of_item
//
//  The front takes one instruction per cycle while the queue has room; busy
//  is the queue-full flag. The back fetches every instruction in its fetch
//  state; a register-type one adds a second-read state, and a second hit adds
//  a flush state; the register table's single read port sets that pace.
//  Results are registered: an immediate-type hit is emitted in the fetch
//  state, a register-type hit in the second-read state, a second in flush.
//  Reset clears the access kinds, the counter and the queue; there is no
//  clearing pass. Results cannot be held off by the receiver.
//
module register_raw_hazard_detector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrhd_pkg::FUNC_W-1:0]   in_func,
  input  logic [rrhd_pkg::REG_W-1:0]    in_src_s,
  input  logic [rrhd_pkg::REG_W-1:0]    in_src_t,
  input  logic [rrhd_pkg::REG_W-1:0]    in_dest_d,
  output logic                          out_valid,
  output logic [rrhd_pkg::REG_W-1:0]    out_hazard_register,
  output logic [rrhd_pkg::NUM_W-1:0]    out_writer_number,
  output logic [rrhd_pkg::NUM_W-1:0]    out_reader_number,
  output logic                          out_last_of_item
);
  import rrhd_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     full;
  logic     head_valid;
  q_entry_t head;
  logic     pop;
  tab_req_t req;
  tab_rsp_t rsp;

  // Stall the input side only when the queue is full.
  assign busy = full;

  // Number the instruction and decode which registers it reads and writes.
  rrhd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .full      (full),
    .in_func   (in_func),
    .in_src_s  (in_src_s),
    .in_src_t  (in_src_t),
    .in_dest_d (in_dest_d),
    .push      (push),
    .entry     (push_entry)
  );

  // Decouple the one-per-cycle front from the multi-cycle back.
  rrhd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Per-register scoreboard: one read and one write each cycle.
  rrhd_regtab u_regtab (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Sequence the accesses in program order and drive the result transaction.
  rrhd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .req                 (req),
    .rsp                 (rsp),
    .out_valid           (out_valid),
    .out_hazard_register (out_hazard_register),
    .out_writer_number   (out_writer_number),
    .out_reader_number   (out_reader_number),
    .out_last_of_item    (out_last_of_item)
  );

endmodule

@@ hw/rtl/rrhd_front.sv @@
// ----------------------------------------------------------------------------
// rrhd_front
// Accepts instructions, numbers them and classifies their register accesses.
// ----------------------------------------------------------------------------
module rrhd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          full,
  input  logic [rrhd_pkg::FUNC_W-1:0]   in_func,
  input  logic [rrhd_pkg::REG_W-1:0]    in_src_s,
  input  logic [rrhd_pkg::REG_W-1:0]    in_src_t,
  input  logic [rrhd_pkg::REG_W-1:0]    in_dest_d,
  output logic                          push,
  output rrhd_pkg::q_entry_t            entry
);
  import rrhd_pkg::*;

  logic [SEQ_WIDTH-1:0] seq_r;
  logic [SEQ_WIDTH-1:0] seq_nxt;

  assign push = start && !full;

  always_comb begin
    entry.src_s  = in_src_s;
    entry.src_t  = in_src_t;
    entry.dest_d = in_dest_d;
    entry.s_ok   = reg_ok(in_src_s);
    entry.t_ok   = reg_ok(in_src_t);
    entry.d_ok   = reg_ok(in_dest_d);
    entry.seq    = seq_r;
    if (in_func == FUNC_RTYPE) begin
      entry.op = OP_RTYPE;
    end else if (in_func == FUNC_ITYPE) begin
      entry.op = OP_ITYPE;
    end else begin
      entry.op = OP_NONE;
    end
  end

  // saturate at the top value
  always_comb begin
    seq_nxt = seq_r;
    if (push && seq_r != SEQ_MAX) begin
      seq_nxt = seq_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

endmodule

@@ hw/rtl/rrhd_queue.sv @@
// ----------------------------------------------------------------------------
// rrhd_queue
// Short FIFO of classified instructions between front and back.
// ----------------------------------------------------------------------------
module rrhd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rrhd_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output rrhd_pkg::q_entry_t head
);
  import rrhd_pkg::*;

  q_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/rrhd_regtab.sv @@
// ----------------------------------------------------------------------------
// rrhd_regtab
// Per-register last access kind and last accessor number.
// ----------------------------------------------------------------------------
module rrhd_regtab (
  input  logic               clk,
  input  logic               rst_n,
  input  rrhd_pkg::tab_req_t req,
  output rrhd_pkg::tab_rsp_t rsp
);
  import rrhd_pkg::*;

  kind_t                kind_r [NUM_REGS];
  logic [SEQ_WIDTH-1:0] last_r [NUM_REGS];

  assign rsp.hazard = req.rd_en && (kind_r[req.rd_idx] == KIND_WRITE);
  assign rsp.writer = last_r[req.rd_idx];

  // the write lands after the read of the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        kind_r[i] <= KIND_NONE;
      end
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (req.wr_en && req.wr_idx == IDX_W'(i)) begin
          kind_r[i] <= KIND_WRITE;
        end else if (req.rd_en && req.rd_idx == IDX_W'(i)) begin
          kind_r[i] <= KIND_READ;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if ((req.wr_en && req.wr_idx == IDX_W'(i)) ||
          (req.rd_en && req.rd_idx == IDX_W'(i))) begin
        last_r[i] <= req.seq;
      end
    end
  end

endmodule

@@ hw/rtl/rrhd_back.sv @@
// ----------------------------------------------------------------------------
// rrhd_back
// Steps through each instruction's accesses and emits RAW transactions.
// ----------------------------------------------------------------------------
module rrhd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  rrhd_pkg::q_entry_t           head,
  output logic                         pop,
  output rrhd_pkg::tab_req_t           req,
  input  rrhd_pkg::tab_rsp_t           rsp,
  output logic                         out_valid,
  output logic [rrhd_pkg::REG_W-1:0]   out_hazard_register,
  output logic [rrhd_pkg::NUM_W-1:0]   out_writer_number,
  output logic [rrhd_pkg::NUM_W-1:0]   out_reader_number,
  output logic                         out_last_of_item
);
  import rrhd_pkg::*;

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_SECOND,
    ST_FLUSH
  } state_t;

  state_t               state_r,   state_nxt;
  q_entry_t             cur_r,     cur_nxt;
  logic                 p_valid_r, p_valid_nxt;
  logic [REG_W-1:0]     p_reg_r,   p_reg_nxt;
  logic [SEQ_WIDTH-1:0] p_wr_r,    p_wr_nxt;

  logic                 emit;
  logic [REG_W-1:0]     emit_reg;
  logic [SEQ_WIDTH-1:0] emit_wr;
  logic [SEQ_WIDTH-1:0] emit_rdr;
  logic                 emit_last;

  logic                 out_valid_r;
  logic [REG_W-1:0]     out_reg_r;
  logic [NUM_W-1:0]     out_wr_r;
  logic [NUM_W-1:0]     out_rdr_r;
  logic                 out_last_r;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    p_valid_nxt = p_valid_r;
    p_reg_nxt   = p_reg_r;
    p_wr_nxt    = p_wr_r;
    pop         = 1'b0;
    req         = '0;
    emit        = 1'b0;
    emit_reg    = p_reg_r;
    emit_wr     = p_wr_r;
    emit_rdr    = cur_r.seq;
    emit_last   = 1'b1;

    unique case (state_r)
      ST_FETCH: begin
        req.seq = head.seq;
        if (head_valid) begin
          pop     = 1'b1;
          cur_nxt = head;
          unique case (head.op)
            OP_RTYPE: begin
              // first read (rt); hold any hit until rs is known
              req.rd_en   = head.t_ok;
              req.rd_idx  = reg_idx(head.src_t);
              p_valid_nxt = rsp.hazard;
              p_reg_nxt   = head.src_t;
              p_wr_nxt    = rsp.writer;
              state_nxt   = ST_SECOND;
            end
            OP_ITYPE: begin
              req.rd_en  = head.s_ok;
              req.rd_idx = reg_idx(head.src_s);
              req.wr_en  = head.t_ok;
              req.wr_idx = reg_idx(head.src_t);
              emit       = rsp.hazard;
              emit_reg   = head.src_s;
              emit_wr    = rsp.writer;
              emit_rdr   = head.seq;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SECOND: begin
        req.seq    = cur_r.seq;
        req.rd_en  = cur_r.s_ok;
        req.rd_idx = reg_idx(cur_r.src_s);
        req.wr_en  = cur_r.d_ok;
        req.wr_idx = reg_idx(cur_r.dest_d);
        state_nxt  = ST_FETCH;
        priority if (p_valid_r && rsp.hazard) begin
          emit      = 1'b1;
          emit_last = 1'b0;
          p_reg_nxt = cur_r.src_s;
          p_wr_nxt  = rsp.writer;
          state_nxt = ST_FLUSH;
        end else if (p_valid_r) begin
          emit        = 1'b1;
          p_valid_nxt = 1'b0;
        end else if (rsp.hazard) begin
          emit     = 1'b1;
          emit_reg = cur_r.src_s;
          emit_wr  = rsp.writer;
        end else begin
          p_valid_nxt = 1'b0;
        end
      end

      ST_FLUSH: begin
        req.seq     = cur_r.seq;
        emit        = 1'b1;
        p_valid_nxt = 1'b0;
        state_nxt   = ST_FETCH;
      end

      default: begin
        state_nxt = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= emit;
      cur_r       <= cur_nxt;
      p_reg_r     <= p_reg_nxt;
      p_wr_r      <= p_wr_nxt;
      if (emit) begin
        out_reg_r  <= emit_reg;
        out_wr_r   <= to_num(emit_wr);
        out_rdr_r  <= to_num(emit_rdr);
        out_last_r <= emit_last;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hazard_register = out_reg_r;
  assign out_writer_number   = out_wr_r;
  assign out_reader_number   = out_rdr_r;
  assign out_last_of_item    = out_last_r;

endmodule

@@ hw/rtl/rrhd_checker.sv @@
// ----------------------------------------------------------------------------
// rrhd_checker
// Port-level checks on the hazard detector, bound to the top level.
// ----------------------------------------------------------------------------
module rrhd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [rrhd_pkg::FUNC_W-1:0]   in_func,
  input logic [rrhd_pkg::REG_W-1:0]    in_src_s,
  input logic [rrhd_pkg::REG_W-1:0]    in_src_t,
  input logic [rrhd_pkg::REG_W-1:0]    in_dest_d,
  input logic                          out_valid,
  input logic [rrhd_pkg::REG_W-1:0]    out_hazard_register,
  input logic [rrhd_pkg::NUM_W-1:0]    out_writer_number,
  input logic [rrhd_pkg::NUM_W-1:0]    out_reader_number,
  input logic                          out_last_of_item
);

  // Reset leaves no transaction on the result side and room on the input.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy active right after reset");

  // An accepted transaction carries known fields.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown({in_func, in_src_s, in_src_t, in_dest_d}))
    else $error("unknown field on accepted input transaction");

  // A non-final transaction is followed at once by the final one.
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item |=> out_valid && out_last_of_item)
    else $error("non-final hazard not followed by final hazard");

  // Both hazards of one instruction carry the same reader number and name
  // two different registers.
  a_same_reader: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item |=>
      out_reader_number == $past(out_reader_number) &&
      out_hazard_register != $past(out_hazard_register))
    else $error("reader number or register wrong within one instruction");

  // The writer always comes before (or, once saturated, equals) the reader.
  a_writer_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_writer_number <= out_reader_number)
    else $error("writer number after reader number");

endmodule

bind register_raw_hazard_detector_core rrhd_checker u_rrhd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_func             (in_func),
  .in_src_s            (in_src_s),
  .in_src_t            (in_src_t),
  .in_dest_d           (in_dest_d),
  .out_valid           (out_valid),
  .out_hazard_register (out_hazard_register),
  .out_writer_number   (out_writer_number),
  .out_reader_number   (out_reader_number),
  .out_last_of_item    (out_last_of_item)
);

@@ dv/register_raw_hazard_detector_core_test.sv @@
// ----------------------------------------------------------------------------
// register_raw_hazard_detector_core_test
// Self-checking bench for the RAW hazard detector. A short table of
// hand-picked instructions runs first, then biased random traffic. Every
// hazard strobe is compared field by field against an in-bench scoreboard.
// ----------------------------------------------------------------------------
module register_raw_hazard_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrhd_pkg::*;

  // Format codes that the package leaves unnamed.
  localparam logic [FUNC_W-1:0] FUNC_JUMP  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_OTHER = 2'd3;

  localparam int N_RANDOM  = 580;
  localparam int TAIL_CYCLES = 32;

  // One RAW hazard as it shows on the result ports.
  typedef struct packed {
    logic [REG_W-1:0] hreg;
    logic [NUM_W-1:0] writer;
    logic [NUM_W-1:0] reader;
    logic             last_hit;
  } hazard_t;

  // One row of the directed table; typed rows carry their hazards inline.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_W-1:0]  src_s;
    logic [REG_W-1:0]  src_t;
    logic [REG_W-1:0]  dest_d;
    logic              typed;
    logic [1:0]        n_hits;
    hazard_t           hit0;
    hazard_t           hit1;
  } instr_row_t;

  localparam hazard_t NO_HIT = '{5'd0, 16'd0, 16'd0, 1'b0};

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [REG_W-1:0]    in_src_s = '0;
  logic [REG_W-1:0]    in_src_t = '0;
  logic [REG_W-1:0]    in_dest_d = '0;
  logic                out_valid;
  logic [REG_W-1:0]    out_hazard_register;
  logic [NUM_W-1:0]    out_writer_number;
  logic [NUM_W-1:0]    out_reader_number;
  logic                out_last_of_item;

  // Shadow of the DUT's register table and sequence counter.
  kind_t                reg_kind [NUM_REGS];
  logic [SEQ_WIDTH-1:0] reg_seq  [NUM_REGS];
  logic [SEQ_WIDTH-1:0] seq_now;

  hazard_t step_hits [$];   // hazards raised by the instruction just issued
  hazard_t hazard_q  [$];   // hazards still owed by the DUT, oldest first

  int n_errors = 0;
  int burst_left = 0;
  logic [REG_W-1:0] hot_regs [4];

  // Hand-picked opening sequence, counter starting from zero after reset.
  // Typed rows cover: cold table, extremes 0 and 31, a double hit, a
  // register read twice in one instruction, and both unused format codes.
  instr_row_t directed_rows [20] = '{
    // cold table: nothing written yet, so no hazard; writes r0
    '{FUNC_RTYPE, 5'd0,  5'd0,  5'd0,  1'b1, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_ITYPE, 5'd0,  5'd31, 5'd0,  1'b1, 2'd1,
      '{5'd0, 16'd0, 16'd1, 1'b1}, NO_HIT},
    // rt and rs both r31: only the first read can hit
    '{FUNC_RTYPE, 5'd31, 5'd31, 5'd5,  1'b1, 2'd1,
      '{5'd31, 16'd1, 16'd2, 1'b1}, NO_HIT},
    '{FUNC_ITYPE, 5'd5,  5'd5,  5'd0,  1'b1, 2'd1,
      '{5'd5, 16'd2, 16'd3, 1'b1}, NO_HIT},
    '{FUNC_ITYPE, 5'd1,  5'd10, 5'd0,  1'b1, 2'd0, NO_HIT, NO_HIT},
    // two hazards from one instruction, rt reported first
    '{FUNC_RTYPE, 5'd10, 5'd5,  5'd31, 1'b1, 2'd2,
      '{5'd5, 16'd3, 16'd5, 1'b0}, '{5'd10, 16'd4, 16'd5, 1'b1}},
    '{FUNC_JUMP,  5'd31, 5'd31, 5'd31, 1'b1, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_OTHER, 5'd31, 5'd31, 5'd31, 1'b1, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_RTYPE, 5'd31, 5'd31, 5'd31, 1'b1, 2'd1,
      '{5'd31, 16'd5, 16'd8, 1'b1}, NO_HIT},
    '{FUNC_ITYPE, 5'd31, 5'd31, 5'd31, 1'b1, 2'd1,
      '{5'd31, 16'd8, 16'd9, 1'b1}, NO_HIT},
    '{FUNC_RTYPE, 5'd31, 5'd0,  5'd31, 1'b1, 2'd1,
      '{5'd31, 16'd9, 16'd10, 1'b1}, NO_HIT},
    // alternating bit patterns, checked against the scoreboard model
    '{FUNC_ITYPE, 5'd21, 5'd10, 5'd0,  1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_RTYPE, 5'd21, 5'd10, 5'd21, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_ITYPE, 5'd21, 5'd21, 5'd10, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_RTYPE, 5'd10, 5'd21, 5'd10, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_RTYPE, 5'd10, 5'd10, 5'd10, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_JUMP,  5'd21, 5'd10, 5'd21, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_OTHER, 5'd10, 5'd21, 5'd10, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_ITYPE, 5'd10, 5'd21, 5'd21, 1'b0, 2'd0, NO_HIT, NO_HIT},
    '{FUNC_RTYPE, 5'd21, 5'd21, 5'd0,  1'b0, 2'd0, NO_HIT, NO_HIT}
  };

  register_raw_hazard_detector_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_src_s            (in_src_s),
    .in_src_t            (in_src_t),
    .in_dest_d           (in_dest_d),
    .out_valid           (out_valid),
    .out_hazard_register (out_hazard_register),
    .out_writer_number   (out_writer_number),
    .out_reader_number   (out_reader_number),
    .out_last_of_item    (out_last_of_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the DUT hangs or drops a hazard.
  initial begin
    #10_000_000;
    $display("register_raw_hazard_detector_core_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard model
  // ---------------------------------------------------------------------------

  // Read one register: raise a hazard if its last access was a write, then
  // mark it read by the current instruction. Out-of-range numbers are dropped.
  task automatic track_read(input logic [REG_W-1:0] r);
    hazard_t h;
    if (int'(r) >= NUM_REGS) return;
    if (reg_kind[r] == KIND_WRITE) begin
      h.hreg     = r;
      h.writer   = NUM_W'(reg_seq[r]);
      h.reader   = NUM_W'(seq_now);
      h.last_hit = 1'b0;
      step_hits.insert(step_hits.size(), h);
    end
    reg_kind[r] = KIND_READ;
    reg_seq[r]  = seq_now;
  endtask

  task automatic track_write(input logic [REG_W-1:0] r);
    if (int'(r) >= NUM_REGS) return;
    reg_kind[r] = KIND_WRITE;
    reg_seq[r]  = seq_now;
  endtask

  // Advance the shadow table by one instruction; hazards land in step_hits.
  task automatic track_instruction(input logic [FUNC_W-1:0] f,
                                   input logic [REG_W-1:0] s,
                                   input logic [REG_W-1:0] t,
                                   input logic [REG_W-1:0] d);
    step_hits.delete();
    case (f)
      FUNC_RTYPE: begin
        // rt is looked up before rs
        track_read(t);
        track_read(s);
        track_write(d);
      end
      FUNC_ITYPE: begin
        track_read(s);
        track_write(t);
      end
      default: begin
        // jump and the spare code touch no register
      end
    endcase
    if (step_hits.size() != 0) step_hits[step_hits.size()-1].last_hit = 1'b1;
    // saturate rather than wrap
    if (seq_now != SEQ_MAX) seq_now++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one instruction and hold it until the DUT takes it. Bursts of
  // random length are separated by random idle gaps. On acceptance, update
  // the model and, unless the caller supplies its own hazards, queue them.
  task automatic issue(input logic [FUNC_W-1:0] f,
                       input logic [REG_W-1:0] s,
                       input logic [REG_W-1:0] t,
                       input logic [REG_W-1:0] d,
                       input bit keep_hits);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    start     <= 1'b1;
    in_func   <= f;
    in_src_s  <= s;
    in_src_t  <= t;
    in_dest_d <= d;
    // busy sampled at the edge is the pre-edge value: accepted when low
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
    track_instruction(f, s, t, d);
    if (keep_hits) begin
      foreach (step_hits[i]) hazard_q.insert(hazard_q.size(), step_hits[i]);
    end
  endtask

  // Drop start and hold off until every queued hazard has come back.
  task automatic drain();
    start <= 1'b0;
    while (hazard_q.size() != 0) @(posedge clk);
  endtask

  // Mostly draw from a few hot registers so that reads keep hitting writes.
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 9) < 7) return hot_regs[$urandom_range(0, 3)];
    return REG_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  task automatic issue_random();
    logic [FUNC_W-1:0] f;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)       f = FUNC_RTYPE;
    else if (sel < 8)  f = FUNC_ITYPE;
    else if (sel == 8) f = FUNC_JUMP;
    else               f = FUNC_OTHER;
    issue(f, pick_reg(), pick_reg(), pick_reg(), 1'b1);
  endtask

  task automatic shuffle_hot();
    foreach (hot_regs[i]) hot_regs[i] = REG_W'($urandom_range(0, NUM_REGS - 1));
  endtask

  initial begin
    // Model starts from the reset state: table cold, counter at zero.
    foreach (reg_kind[i]) begin
      reg_kind[i] = KIND_NONE;
      reg_seq[i]  = '0;
    end
    seq_now = '0;
    shuffle_hot();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed rows queue their inline hazards; the rest use
    // the model's prediction.
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].func, directed_rows[i].src_s, directed_rows[i].src_t,
            directed_rows[i].dest_d, !directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].n_hits > 0)
          hazard_q.insert(hazard_q.size(), directed_rows[i].hit0);
        if (directed_rows[i].n_hits > 1)
          hazard_q.insert(hazard_q.size(), directed_rows[i].hit1);
      end
    end

    // Let the pipeline empty completely before random traffic.
    drain();

    // Random traffic: refresh the hot set now and then, and once in a
    // while stall until the DUT has caught up.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 99) shuffle_hot();
      if ($urandom_range(0, 99) == 0) drain();
      issue_random();
    end

    // Wait for the last hazards, then a tail to catch any stray strobe.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("register_raw_hazard_detector_core_test: clean");
    end else begin
      $display("register_raw_hazard_detector_core_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checker: each strobe must match the oldest queued hazard.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hazard_t want;
    if (rst_n && out_valid) begin
      if (hazard_q.size() == 0) begin
        $error("unexpected hazard transaction: register %0d writer %0d reader %0d",
               out_hazard_register, out_writer_number, out_reader_number);
        n_errors++;
      end else begin
        want = hazard_q.pop_front();
        if (out_hazard_register !== want.hreg) begin
          $error("hazard_register: expected %0d, actual %0d", want.hreg,
                 out_hazard_register);
          n_errors++;
        end
        if (out_writer_number !== want.writer) begin
          $error("writer_number: expected %0d, actual %0d", want.writer,
                 out_writer_number);
          n_errors++;
        end
        if (out_reader_number !== want.reader) begin
          $error("reader_number: expected %0d, actual %0d", want.reader,
                 out_reader_number);
          n_errors++;
        end
        if (out_last_of_item !== want.last_hit) begin
          $error("last_of_item: expected %0d, actual %0d", want.last_hit,
                 out_last_of_item);
          n_errors++;
        end
      end
    end
  end

endmodule
